>>> sv/heap_usage_tracker_macros.svh
// Assertion macros shared by the heap usage tracker RTL.
`ifndef HEAP_USAGE_TRACKER_MACROS_SVH
`define HEAP_USAGE_TRACKER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HUT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/hut_pkg.sv
// Package with the constants, codes and widths of the heap usage tracker.
`default_nettype none
package hut_pkg;
  localparam int HEAP_SLOTS_DEF   = 4;
  localparam int TYPE_SLOTS_DEF   = 32;
  localparam int LIVE_ENTRIES_DEF = 256;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 184;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int HANDLE_W = 64;
  localparam int BYTES_W  = 48;
  localparam int HEAP_W   = 2;
  localparam int ENTRY_W  = 1 + HEAP_W + BYTES_W + HANDLE_W;
  localparam int DIV_STEPS = 44;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_QUERY   = 3'd5;

  localparam logic [2:0] REG_MAP_LO    = 3'd0;
  localparam logic [2:0] REG_MAP_HI    = 3'd1;
  localparam logic [2:0] REG_SIZES_LO  = 3'd2;
  localparam logic [2:0] REG_SIZES_HI  = 3'd3;
  localparam logic [2:0] REG_TYPE_CNT  = 3'd4;
  localparam logic [2:0] REG_HEAP_CNT  = 3'd5;
  localparam logic [2:0] REG_STEP_MIB  = 3'd6;
  localparam logic [2:0] REG_LOG_EN    = 3'd7;

  localparam logic [1:0] PRESS_LOW  = 2'd0;
  localparam logic [1:0] PRESS_MID  = 2'd1;
  localparam logic [1:0] PRESS_HIGH = 2'd2;
endpackage
`default_nettype wire

>>> sv/hut_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module hut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> sv/heap_usage_tracker.sv
// Top level of the heap usage tracker: live table scan, heap counters and thresholds.
//
// Channel  Dir  Handshake          Contents
// s_       in   tvalid/tready      tuser mode; tdata handle, type, bytes, query heap
// m_       out  tvalid/tready      tuser status; tdata heap, held, peak, crossed, ...
// cfg_     in   cfg_we             cfg_index, cfg_data
//
// After reset every entry of the live table is cleared before the first word is taken.
// A query or an ignored word skips the live table scan.
// An allocation or free that passes its checks scans the live table RAM one entry a cycle.
// A threshold crossing adds a bit-serial remainder by the step size before the new threshold.
// One word is in work at a time; a finished result waits until the output register is free.
`default_nettype none
module heap_usage_tracker #(
  parameter int HEAP_SLOTS   = hut_pkg::HEAP_SLOTS_DEF,
  parameter int TYPE_SLOTS   = hut_pkg::TYPE_SLOTS_DEF,
  parameter int LIVE_ENTRIES = hut_pkg::LIVE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // handle[63:0], mem_type[71:64], bytes[119:72], query_heap[123:120]
  input  wire logic [hut_pkg::IN_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  wire logic [1:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // heap_index[1:0], held_bytes[65:2], peak_bytes[129:66], crossed[130],
  // pressure[132:131], freed_bytes[180:133]
  output logic [hut_pkg::OUT_DATA_W-1:0]      m_tdata,
  // status[2:0]
  output logic [2:0]                          m_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [hut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hut_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hut_pkg::*;

  localparam int AW = $clog2(LIVE_ENTRIES);
  localparam int HW = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(LIVE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_THR   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;

  logic [63:0] map_lo, map_hi, sizes_lo, sizes_hi;
  logic [5:0]  type_num;
  logic [2:0]  heap_num;
  logic [31:0] step_mib;
  logic        log_en;

  logic [63:0] held [HEAP_SLOTS];
  logic [63:0] peak [HEAP_SLOTS];
  logic [63:0] thr  [HEAP_SLOTS];

  logic [1:0]  in_mode;
  logic [63:0] in_handle;
  logic [7:0]  in_type;
  logic [47:0] in_bytes;
  logic [3:0]  in_qheap;
  logic [1:0]  cur_heap;

  logic [AW-1:0] iss_addr;
  logic          iss_done;
  logic          chk_v;
  logic [AW-1:0] chk_idx;
  logic          mt_found, fr_found;
  logic [AW-1:0] mt_idx, fr_idx;
  logic [47:0]   mt_size;
  logic [1:0]    mt_heap;

  logic [31:0] div_rem;
  logic [43:0] div_dv;
  logic [5:0]  div_cnt;

  logic [2:0]  r_status;
  logic [1:0]  r_heap;
  logic [63:0] r_held, r_peak;
  logic        r_crossed;
  logic [1:0]  r_pressure;
  logic [47:0] r_freed;

  logic [2:0]  o_status;
  logic [1:0]  o_heap;
  logic [63:0] o_held, o_peak;
  logic        o_crossed;
  logic [1:0]  o_pressure;
  logic [47:0] o_freed;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [5:0]  types_eff;
  logic [2:0]  heaps_eff;
  logic [63:0] map_word;
  logic [3:0]  nib;
  logic        alloc_ok;
  logic [31:0] step_eff;
  logic [63:0] step_b;
  logic [64:0] add_sum;
  logic [63:0] held_new, peak_new, thr_eff;
  logic [64:0] sub_diff;
  logic [32:0] div_t;
  logic [63:0] base;
  logic [64:0] thr_sum;
  logic [31:0] size_mib;
  logic [51:0] size_b;
  logic [67:0] held10, size9, size7;
  logic        out_load;
  logic [HW-1:0] hc, hm;

  hut_ram #(.WIDTH(ENTRY_W), .DEPTH(LIVE_ENTRIES)) u_live (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(iss_addr), .rdata(ram_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign m_tdata  = {3'b0, o_freed, o_pressure, o_crossed, o_peak, o_held, o_heap};
  assign m_tuser  = o_status;

  assign hc = cur_heap[HW-1:0];
  assign hm = mt_heap[HW-1:0];

  always_comb begin
    types_eff = (type_num > 6'(TYPE_SLOTS)) ? 6'(TYPE_SLOTS) : type_num;
    heaps_eff = (heap_num > 3'(HEAP_SLOTS)) ? 3'(HEAP_SLOTS) : heap_num;
    map_word  = in_type[4] ? map_hi : map_lo;
    nib       = map_word[{in_type[3:0], 2'b00} +: 4];
    alloc_ok  = (in_bytes != '0) && (in_handle != '0) && (in_type < {2'b00, types_eff})
                && (nib < {1'b0, heaps_eff}) && (in_type[7:5] == 3'b000);
    step_eff  = (step_mib == '0) ? 32'd256 : step_mib;
    step_b    = {12'b0, step_eff, 20'b0};
    add_sum   = {1'b0, held[hc]} + {17'b0, in_bytes};
    held_new  = add_sum[64] ? '1 : add_sum[63:0];
    peak_new  = (held_new > peak[hc]) ? held_new : peak[hc];
    thr_eff   = (thr[hc] != '0) ? thr[hc] : step_b;
    sub_diff  = {1'b0, held[hm]} - {17'b0, mt_size};
    div_t     = {div_rem, div_dv[43]};
    base      = r_held - {12'b0, div_rem, r_held[19:0]};
    thr_sum   = {1'b0, base} + {1'b0, step_b};
    size_mib  = cur_heap[0] ? (cur_heap[1] ? sizes_hi[63:32] : sizes_lo[63:32])
                            : (cur_heap[1] ? sizes_hi[31:0]  : sizes_lo[31:0]);
    size_b    = {size_mib, 20'b0};
    held10    = {1'b0, r_held, 3'b0} + {3'b0, r_held, 1'b0};
    size9     = {13'b0, size_b, 3'b0} + {16'b0, size_b};
    size7     = {13'b0, size_b, 3'b0} - {16'b0, size_b};
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = iss_addr;
    ram_wdata = '0;
    ram_re    = (state == S_SCAN) && !iss_done;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_APPLY) begin
      if (in_mode == MODE_ALLOC && (mt_found || fr_found)) begin
        ram_we    = 1'b1;
        ram_waddr = mt_found ? mt_idx : fr_idx;
        ram_wdata = {1'b1, cur_heap, in_bytes, in_handle};
      end else if (in_mode == MODE_FREE && mt_found) begin
        ram_we    = 1'b1;
        ram_waddr = mt_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_lo <= '0; map_hi <= '0; sizes_lo <= '0; sizes_hi <= '0;
      type_num <= '0; heap_num <= '0; step_mib <= 32'd256; log_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_LO:   map_lo <= cfg_data;
        REG_MAP_HI:   map_hi <= cfg_data;
        REG_SIZES_LO: sizes_lo <= cfg_data;
        REG_SIZES_HI: sizes_hi <= cfg_data;
        REG_TYPE_CNT: type_num <= cfg_data[5:0];
        REG_HEAP_CNT: heap_num <= cfg_data[2:0];
        REG_STEP_MIB: step_mib <= cfg_data[31:0];
        REG_LOG_EN:   log_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      iss_addr <= '0;
      iss_done <= 1'b0;
      chk_v    <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < HEAP_SLOTS; i++) begin
        held[i] <= '0;
        peak[i] <= '0;
        thr[i]  <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (iss_addr == LAST) begin
            iss_addr <= '0;
            state    <= S_IDLE;
          end else begin
            iss_addr <= iss_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            in_mode   <= s_tuser;
            in_handle <= s_tdata[63:0];
            in_type   <= s_tdata[71:64];
            in_bytes  <= s_tdata[119:72];
            in_qheap  <= s_tdata[123:120];
            state     <= S_DEC;
          end
        end
        S_DEC: begin
          r_crossed <= 1'b0; r_pressure <= PRESS_LOW; r_freed <= '0;
          iss_addr <= '0; iss_done <= 1'b0; chk_v <= 1'b0;
          mt_found <= 1'b0; fr_found <= 1'b0;
          cur_heap <= nib[1:0];
          r_status <= (in_mode == MODE_QUERY) ? ST_QUERY : ST_IGNORED;
          if (in_mode == MODE_QUERY && in_qheap < 4'(HEAP_SLOTS)) begin
            r_heap <= in_qheap[1:0];
            r_held <= held[in_qheap[HW-1:0]];
            r_peak <= peak[in_qheap[HW-1:0]];
          end else begin
            r_heap <= '0;
            r_held <= '0;
            r_peak <= '0;
          end
          if ((in_mode == MODE_ALLOC && alloc_ok) ||
              (in_mode == MODE_FREE && in_handle != '0)) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          chk_v   <= !iss_done;
          chk_idx <= iss_addr;
          if (!iss_done) begin
            if (iss_addr == LAST) iss_done <= 1'b1;
            else iss_addr <= iss_addr + AW'(1);
          end
          if (chk_v) begin
            if (ram_rdata[ENTRY_W-1] && ram_rdata[63:0] == in_handle) begin
              mt_found <= 1'b1;
              mt_idx   <= chk_idx;
              mt_size  <= ram_rdata[111:64];
              mt_heap  <= ram_rdata[113:112];
            end
            if (!ram_rdata[ENTRY_W-1] && !fr_found) begin
              fr_found <= 1'b1;
              fr_idx   <= chk_idx;
            end
            if (chk_idx == LAST) state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (in_mode == MODE_ALLOC) begin
            r_heap <= cur_heap;
            if (!mt_found && !fr_found) begin
              r_status <= ST_FULL;
              r_held   <= held[hc];
              r_peak   <= peak[hc];
              state    <= S_DONE;
            end else begin
              r_status <= ST_COUNTED;
              r_held   <= held_new;
              r_peak   <= peak_new;
              held[hc] <= held_new;
              peak[hc] <= peak_new;
              if (log_en && held_new >= thr_eff) begin
                r_crossed <= 1'b1;
                div_rem   <= '0;
                div_dv    <= held_new[63:20];
                div_cnt   <= '0;
                state     <= S_DIV;
              end else begin
                state <= S_DONE;
              end
            end
          end else begin
            state <= S_DONE;
            if (mt_found) begin
              cur_heap  <= mt_heap;
              r_status  <= ST_FREED;
              r_heap    <= mt_heap;
              r_held    <= sub_diff[64] ? '0 : sub_diff[63:0];
              r_peak    <= peak[hm];
              r_freed   <= mt_size;
              held[hm]  <= sub_diff[64] ? '0 : sub_diff[63:0];
            end else begin
              r_status <= ST_UNKNOWN;
            end
          end
        end
        S_DIV: begin
          div_rem <= (div_t >= {1'b0, step_eff}) ? 32'(div_t - {1'b0, step_eff})
                                                 : div_t[31:0];
          div_dv  <= {div_dv[42:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(DIV_STEPS - 1)) state <= S_THR;
        end
        S_THR: begin
          thr[hc] <= thr_sum[64] ? '1 : thr_sum[63:0];
          if (size_mib == '0) r_pressure <= PRESS_LOW;
          else if (held10 >= size9) r_pressure <= PRESS_HIGH;
          else if (held10 >= size7) r_pressure <= PRESS_MID;
          else r_pressure <= PRESS_LOW;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status   <= r_status;
      o_heap     <= r_heap;
      o_held     <= r_held;
      o_peak     <= r_peak;
      o_crossed  <= r_crossed;
      o_pressure <= r_pressure;
      o_freed    <= r_freed;
    end
  end

`include "heap_usage_tracker_macros.svh"

  `HUT_ASSERT_IMP(a_no_accept_in_clear, state == S_CLEAR, !s_tready, "word taken in clear")
  `HUT_ASSERT_NEXT(a_scan_ends, state == S_SCAN && chk_v && chk_idx == LAST, state == S_APPLY, "scan")
  `HUT_ASSERT_IMP(a_peak_ge_held, out_load && r_status == ST_COUNTED, r_peak >= r_held, "peak low")
  `HUT_ASSERT_IMP(a_free_no_cross, out_load && r_status == ST_FREED, !r_crossed, "free crossed")
  `HUT_ASSERT_NEXT(a_result_shown, out_load, m_tvalid, "result not presented")
endmodule
`default_nettype wire

>>> tb/sv/heap_usage_tracker_tb.sv
// Self-checking testbench for the heap usage tracker: directed table, random phases, predictor.
`timescale 1ns / 1ps
module heap_usage_tracker_tb;
  import hut_pkg::*;

  localparam logic [1:0] MODE_NOOP = 2'd3;
  localparam int LIVE_N = 256;
  localparam int PHASES = 11;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  heap;
    logic [63:0] held;
    logic [63:0] peak;
    logic        crossed;
    logic [1:0]  press;
    logic [47:0] freed;
  } usage_t;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] handle;
    logic [7:0]  mtype;
    logic [47:0] nbytes;
    logic [3:0]  qheap;
    bit          typed;
    logic [2:0]  status;
  } word_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heap_usage_tracker i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Shadow copy of the layout registers and the accounting state.
  logic [63:0] map_lo, map_hi, sizes_lo, sizes_hi;
  logic [5:0]  type_cnt;
  logic [2:0]  heap_cnt;
  logic [31:0] step_mib;
  logic        log_en;
  logic [63:0] held_q [4];
  logic [63:0] peak_q [4];
  logic [63:0] next_thr [4];
  bit          live_ok [LIVE_N];
  logic [63:0] live_hdl [LIVE_N];
  logic [47:0] live_len [LIVE_N];
  logic [1:0]  live_hp [LIVE_N];

  usage_t pending_usage [$];
  int errors = 0;
  int words_out = 0;
  int words_in = 0;
  int crossings = 0;
  int fulls = 0;
  int layouts = 0;
  bit quiet = 0;

  function automatic logic [1:0] grade_pressure(logic [63:0] held, logic [1:0] h);
    logic [31:0]  mib;
    logic [127:0] size;
    mib = (h < 2) ? (h[0] ? sizes_lo[63:32] : sizes_lo[31:0])
                  : (h[0] ? sizes_hi[63:32] : sizes_hi[31:0]);
    size = {96'd0, mib} << 20;
    if (size == 0) return PRESS_LOW;
    if ({64'd0, held} >= (90 * size + 99) / 100) return PRESS_HIGH;
    if ({64'd0, held} >= (70 * size + 99) / 100) return PRESS_MID;
    return PRESS_LOW;
  endfunction

  function automatic usage_t account_word(logic [1:0] mode, logic [63:0] hdl, logic [7:0] mt,
                                          logic [47:0] nb, logic [3:0] qh);
    usage_t r;
    int slot;
    int types, heaps;
    logic [63:0] map, step, thr, held;
    logic [127:0] nxt;
    logic [3:0] nib;
    logic [1:0] h;
    r = '0;
    r.status = ST_IGNORED;
    slot = -1;
    if (mode == MODE_ALLOC) begin
      types = (type_cnt > 32) ? 32 : type_cnt;
      heaps = (heap_cnt > 4) ? 4 : heap_cnt;
      if (nb == 0 || hdl == 0 || mt >= types) return r;
      map = (mt < 16) ? map_lo : map_hi;
      nib = map[mt[3:0] * 4 +: 4];
      if (nib >= heaps) return r;
      h = nib[1:0];
      for (int i = 0; i < LIVE_N; i++)
        if (slot < 0 && live_ok[i] && live_hdl[i] == hdl) slot = i;
      for (int i = 0; i < LIVE_N; i++)
        if (slot < 0 && !live_ok[i]) slot = i;
      r.heap = h;
      if (slot < 0) begin
        r.status = ST_FULL;
        r.held = held_q[h];
        r.peak = peak_q[h];
        return r;
      end
      live_ok[slot] = 1;
      live_hdl[slot] = hdl;
      live_len[slot] = nb;
      live_hp[slot] = h;
      held = (held_q[h] > 64'hFFFF_FFFF_FFFF_FFFF - nb) ? '1 : held_q[h] + nb;
      held_q[h] = held;
      if (held > peak_q[h]) peak_q[h] = held;
      r.status = ST_COUNTED;
      r.held = held;
      r.peak = peak_q[h];
      if (log_en) begin
        step = {32'd0, (step_mib == 0) ? 32'd256 : step_mib} << 20;
        thr = (next_thr[h] != 0) ? next_thr[h] : step;
        if (held >= thr) begin
          nxt = {64'd0, (held / step) * step} + {64'd0, step};
          next_thr[h] = (nxt > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : nxt[63:0];
          r.crossed = 1;
          r.press = grade_pressure(held, h);
        end
      end
    end else if (mode == MODE_FREE) begin
      if (hdl == 0) return r;
      for (int i = 0; i < LIVE_N; i++)
        if (slot < 0 && live_ok[i] && live_hdl[i] == hdl) slot = i;
      if (slot < 0) begin
        r.status = ST_UNKNOWN;
        return r;
      end
      h = live_hp[slot];
      live_ok[slot] = 0;
      held_q[h] = ({16'd0, live_len[slot]} > held_q[h]) ? 64'd0 : held_q[h] - live_len[slot];
      r.status = ST_FREED;
      r.heap = h;
      r.held = held_q[h];
      r.peak = peak_q[h];
      r.freed = live_len[slot];
    end else if (mode == MODE_QUERY) begin
      r.status = ST_QUERY;
      if (qh < 4) begin
        r.heap = qh[1:0];
        r.held = held_q[qh];
        r.peak = peak_q[qh];
      end
    end
    return r;
  endfunction

  task automatic write_layout(logic [2:0] idx, logic [63:0] value);
    s_tvalid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MAP_LO:   map_lo = value;
      REG_MAP_HI:   map_hi = value;
      REG_SIZES_LO: sizes_lo = value;
      REG_SIZES_HI: sizes_hi = value;
      REG_TYPE_CNT: type_cnt = value[5:0];
      REG_HEAP_CNT: heap_cnt = value[2:0];
      REG_STEP_MIB: step_mib = value[31:0];
      default:      log_en = value[0];
    endcase
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (pending_usage.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] mode, logic [63:0] hdl, logic [7:0] mt, logic [47:0] nb,
                           logic [3:0] qh, bit typed, logic [2:0] st);
    int gap;
    usage_t r;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {4'd0, qh, nb, mt, hdl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = account_word(mode, hdl, mt, nb, qh);
    if (typed) begin
      r = '0;
      r.status = st;
    end
    if (r.crossed) crossings++;
    if (r.status == ST_FULL) fulls++;
    pending_usage.push_back(r);
    words_in++;
  endtask

  function automatic logic [63:0] fresh_handle();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic logic [63:0] live_pick();
    int start;
    start = $urandom_range(0, LIVE_N - 1);
    for (int i = 0; i < LIVE_N; i++)
      if (live_ok[(start + i) % LIVE_N]) return live_hdl[(start + i) % LIVE_N];
    return fresh_handle();
  endfunction

  function automatic logic [63:0] random_map();
    logic [63:0] v;
    for (int i = 0; i < 16; i++)
      v[i * 4 +: 4] = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3));
    return v;
  endfunction

  function automatic logic [31:0] random_size();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  task automatic random_word(int free_pct);
    int pick;
    logic [63:0] hdl;
    logic [7:0] mt;
    logic [47:0] nb;
    pick = $urandom_range(0, 99);
    mt = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    nb = 48'({$urandom, $urandom} >> $urandom_range(0, 63 - 20));
    if ($urandom_range(0, 3) == 0) nb = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
    if (pick < free_pct) begin
      hdl = ($urandom_range(0, 4) == 0) ? fresh_handle() : live_pick();
      send_word(MODE_FREE, hdl, mt, nb, 4'($urandom), 0, ST_IGNORED);
    end else if (pick < 85) begin
      hdl = ($urandom_range(0, 9) == 0) ? live_pick() : fresh_handle();
      send_word(MODE_ALLOC, hdl, mt, nb, 4'($urandom), 0, ST_IGNORED);
    end else if (pick < 95) begin
      send_word(MODE_QUERY, fresh_handle(), mt, nb, 4'($urandom), 0, ST_IGNORED);
    end else begin
      case ($urandom_range(0, 3))
        0: send_word(MODE_NOOP, fresh_handle(), mt, nb, 4'($urandom), 0, ST_IGNORED);
        1: send_word(MODE_ALLOC, 64'd0, mt, nb, 4'($urandom), 0, ST_IGNORED);
        2: send_word(MODE_ALLOC, fresh_handle(), mt, 48'd0, 4'($urandom), 0, ST_IGNORED);
        default: send_word(MODE_FREE, 64'd0, mt, nb, 4'($urandom), 0, ST_IGNORED);
      endcase
    end
  endtask

  // Directed words: the first six run on the reset layout, the rest on the first layout.
  word_row_t directed [] = '{
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd0, 1, ST_QUERY},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd15, 1, ST_QUERY},
    '{MODE_NOOP, 64'd9, 8'd0, 48'd1, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, '1, 8'd0, 48'd1, 4'd0, 1, ST_IGNORED},
    '{MODE_FREE, 64'd5, 8'd0, 48'd0, 4'd0, 1, ST_UNKNOWN},
    '{MODE_FREE, 64'd0, 8'd0, 48'd0, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, '1, 8'd0, 48'd7 << 20, 4'd0, 0, ST_IGNORED},
    '{MODE_ALLOC, 64'd2, 8'd4, 48'd2 << 20, 4'd0, 0, ST_IGNORED},
    '{MODE_ALLOC, 64'd3, 8'd2, 48'd3 << 20, 4'd0, 0, ST_IGNORED},
    '{MODE_ALLOC, 64'd6, 8'd3, 48'd1, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, 64'd6, 8'd20, 48'd1, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, 64'd6, 8'd255, 48'd1, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, 64'd6, 8'd1, 48'd0, 4'd0, 1, ST_IGNORED},
    '{MODE_ALLOC, 64'd4, 8'd1, '1, 4'd0, 0, ST_IGNORED},
    '{MODE_ALLOC, '1, 8'd0, 48'd1 << 20, 4'd0, 0, ST_IGNORED},
    '{MODE_FREE, '1, 8'd0, 48'd0, 4'd0, 0, ST_IGNORED},
    '{MODE_FREE, '1, 8'd0, 48'd0, 4'd0, 1, ST_UNKNOWN},
    '{MODE_FREE, 64'd2, 8'd0, 48'd0, 4'd0, 0, ST_IGNORED},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd0, 0, ST_IGNORED},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd1, 0, ST_IGNORED},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd2, 0, ST_IGNORED},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd3, 0, ST_IGNORED},
    '{MODE_QUERY, 64'd0, 8'd0, 48'd0, 4'd4, 1, ST_QUERY}
  };

  initial begin
    map_lo = 0; map_hi = 0; sizes_lo = 0; sizes_hi = 0;
    type_cnt = 0; heap_cnt = 0; step_mib = 256; log_en = 1;
    for (int i = 0; i < 4; i++) begin
      held_q[i] = 0; peak_q[i] = 0; next_thr[i] = 0;
    end
    for (int i = 0; i < LIVE_N; i++) live_ok[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < directed.size(); i++) begin
      if (i == 6) begin
        wait_drained();
        write_layout(REG_MAP_LO, 64'h3210_3210_3210_3210);
        write_layout(REG_MAP_HI, 64'h3210_3210_3210_3210);
        write_layout(REG_SIZES_LO, {32'd100, 32'd10});
        write_layout(REG_SIZES_HI, {32'hFFFF_FFFF, 32'd0});
        write_layout(REG_TYPE_CNT, 64'd20);
        write_layout(REG_HEAP_CNT, 64'd3);
        write_layout(REG_STEP_MIB, 64'd1);
        write_layout(REG_LOG_EN, 64'd1);
        layouts++;
      end
      send_word(directed[i].mode, directed[i].handle, directed[i].mtype, directed[i].nbytes,
                directed[i].qheap, directed[i].typed, directed[i].status);
    end
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      quiet = (p % 4 == 3);
      write_layout(REG_MAP_LO, (p == 1) ? '1 : random_map());
      write_layout(REG_MAP_HI, random_map());
      write_layout(REG_SIZES_LO, {random_size(), random_size()});
      write_layout(REG_SIZES_HI, {random_size(), random_size()});
      write_layout(REG_TYPE_CNT, (p == 1) ? 64'd63 : (p == 2) ? 64'd0 : (p >= 9) ? 64'd32 :
                   {$urandom, 26'd0, 6'($urandom_range(8, 40))});
      write_layout(REG_HEAP_CNT, (p == 1) ? 64'd7 : (p == 4) ? 64'd0 : (p >= 9) ? 64'd4 :
                   {$urandom, 29'd0, 3'($urandom_range(1, 7))});
      write_layout(REG_STEP_MIB, (p == 1) ? 64'hFFFF_FFFF : (p == 5) ? 64'd0 :
                   {$urandom, 32'($urandom_range(1, 16))});
      write_layout(REG_LOG_EN, (p == 1 || p == 6) ? 64'd0 : {$urandom, 31'd0, 1'b1});
      layouts++;
      if (p == 9) begin
        for (int j = 0; j < 280; j++)
          send_word(MODE_ALLOC, fresh_handle(), 8'($urandom_range(0, 31)),
                    48'($urandom_range(1, 1 << 22)), 4'd0, 0, ST_IGNORED);
      end else begin
        for (int j = 0; j < 110; j++) random_word((p == 10) ? 70 : 25);
      end
    end
    wait_drained();
    $display("Ran %0d words over %0d layouts: %0d threshold crossings, %0d full-table results.",
             words_in, layouts, crossings, fulls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold so the block backs up.
  initial begin
    int k;
    bit held_off;
    held_off = 0;
    forever begin
      k = quiet ? 0 : $urandom_range(0, 4);
      if (!held_off && words_out >= 300) begin
        held_off = 1;
        k = 2000;
      end
      if (k > 0) begin
        m_tready <= 0;
        repeat (k) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    usage_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[1:0], m_tdata[65:2], m_tdata[129:66], m_tdata[130],
             m_tdata[132:131], m_tdata[180:133]};
      words_out++;
      if (pending_usage.size() == 0) begin
        $display("%0t: unexpected word status=%0d", $time, got.status);
        errors++;
      end else begin
        want = pending_usage.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d heap=%0d held=%h peak=%h x=%b pr=%0d fr=%h",
                   $time, want.status, want.heap, want.held, want.peak, want.crossed,
                   want.press, want.freed);
          $display("%0t:          actual   st=%0d heap=%0d held=%h peak=%h x=%b pr=%0d fr=%h",
                   $time, got.status, got.heap, got.held, got.peak, got.crossed,
                   got.press, got.freed);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d words outstanding.", pending_usage.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule
